// File: design/tws_pkg.sv
// tws_pkg: shared types and constants for the three-wire serial register master
// depends on nothing; used by the channel interfaces, the step core and the top level

package tws_pkg;

   // bits in one serial byte
   localparam int unsigned BYTE_BITS = 8;
   // width of the outgoing shift register: command byte then data byte
   localparam int unsigned SHIFT_W = 2 * BYTE_BITS;
   // half-period phases of one transfer before the closing tick
   localparam int unsigned TOTAL_PHASES = 4 * BYTE_BITS;
   localparam int unsigned PHASE_W = $clog2(TOTAL_PHASES + 1);

   // operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   // unused code, behaves as a plain tick
   localparam logic [1:0] OP_NONE = 2'd3;

   // command byte pieces
   localparam logic [BYTE_BITS-1:0] CMD_BASE = 8'h80;
   localparam logic [BYTE_BITS-1:0] CMD_RAM = 8'h40;
   localparam logic [BYTE_BITS-1:0] CMD_READ = 8'h01;

   typedef struct packed {
      logic [1:0] operation;
      logic ram_select;
      logic [4:0] reg_index;
      logic [BYTE_BITS-1:0] write_data;
      logic line_sample;
   } req_word_type;

   typedef struct packed {
      logic clock_pin;
      logic enable_pin;
      logic data_pin;
      logic data_drive;
      logic [BYTE_BITS-1:0] read_byte;
      logic read_done;
      logic busy_res;
      logic start_rejected;
   } rsp_word_type;

endpackage

// File: design/tws_channels.sv
// tws_channels: valid/ready channel interfaces for request and response words
// depends on tws_pkg for the payload types

interface tws_req_if;
   logic valid;
   logic ready;
   tws_pkg::req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tws_rsp_if;
   logic valid;
   logic ready;
   tws_pkg::rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/three_wire_serial_register_master.sv
// three_wire_serial_register_master: top level with request and response registers
// depends on tws_pkg, tws_channels and tws_core
//
//  channel  role   word contents
//  req_ch   sink   operation, ram_select, reg_index, write_data, line_sample
//  rsp_ch   source pin levels, read_byte, read_done, busy_res, start_rejected
//
// one request word per cycle in while the response side is not stalled, one response word per request out
// a request passes through the request register, then the step logic into the response register
// each request word is one half period of the serial clock; the transfer state
// lives in the step core and advances only when a word moves to the response register
// synchronous active-high reset clears valid flags and the transfer state
// a stalled response holds; the request register still takes one more word meanwhile

module three_wire_serial_register_master (
   input logic clock,
   input logic reset,
   tws_req_if.sink req_ch,
   tws_rsp_if.source rsp_ch
);

   logic req_valid_ff, req_valid_in;
   tws_pkg::req_word_type req_data_ff;
   logic rsp_valid_ff, rsp_valid_in;
   tws_pkg::rsp_word_type rsp_data_ff;

   logic advance;
   logic move;
   logic take;
   tws_pkg::rsp_word_type step_word;

   // response slot is free or being emptied this cycle
   assign advance = !rsp_valid_ff || rsp_ch.ready;
   // held request word steps into the response register
   assign move = req_valid_ff && advance;
   assign req_ch.ready = !req_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (take) begin
         req_valid_in = 1'b1;
      end else if (move) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         req_data_ff <= req_ch.payload;
      end
      if (move) begin
         rsp_data_ff <= step_word;
      end
   end

   // transfer state and per-tick decode
   tws_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (move),
      .req_word (req_data_ff),
      .rsp_word (step_word)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("stepped word did not reach the response register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_data_ff)))
      else $error("held request word lost while response stalled");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      take |-> (!req_valid_ff || move))
      else $error("request register overwritten");

endmodule

// File: design/tws_core.sv
// tws_core: transfer state registers and the per-tick step logic
// depends on tws_pkg

module tws_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tws_pkg::req_word_type req_word,
   output tws_pkg::rsp_word_type rsp_word
);

   logic [tws_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [tws_pkg::SHIFT_W-1:0] out_shift_ff, out_shift_in;
   logic [tws_pkg::BYTE_BITS-1:0] in_shift_ff, in_shift_in;
   logic is_read_ff, is_read_in;
   logic active_ff, active_in;

   logic start;
   logic start_read;
   logic [tws_pkg::BYTE_BITS-1:0] cmd;
   logic [tws_pkg::PHASE_W-1:0] cur_phase;
   logic [tws_pkg::SHIFT_W-1:0] cur_out;
   logic [tws_pkg::BYTE_BITS-1:0] cur_in;
   logic cur_read;
   logic reading;

   assign start = (req_word.operation == tws_pkg::OP_WRITE) ||
                  (req_word.operation == tws_pkg::OP_READ);
   assign start_read = (req_word.operation == tws_pkg::OP_READ);
   assign cmd = tws_pkg::CMD_BASE
              | (req_word.ram_select ? tws_pkg::CMD_RAM : '0)
              | {2'b00, req_word.reg_index, 1'b0}
              | (start_read ? tws_pkg::CMD_READ : '0);

   always_comb begin
      // state seen by this tick: a fresh start loads the command first
      cur_phase = phase_ff;
      cur_out = out_shift_ff;
      cur_in = in_shift_ff;
      cur_read = is_read_ff;
      if (!active_ff && start) begin
         cur_phase = '0;
         cur_out = {req_word.write_data, cmd};
         cur_in = '0;
         cur_read = start_read;
      end
      reading = cur_read && (cur_phase >= tws_pkg::PHASE_W'(2 * tws_pkg::BYTE_BITS));

      rsp_word = '0;
      phase_in = phase_ff;
      out_shift_in = out_shift_ff;
      in_shift_in = in_shift_ff;
      is_read_in = is_read_ff;
      active_in = active_ff;

      if (active_ff || start) begin
         rsp_word.busy_res = active_ff;
         rsp_word.start_rejected = active_ff && start;
         out_shift_in = cur_out;
         in_shift_in = cur_in;
         is_read_in = cur_read;
         if (cur_phase < tws_pkg::PHASE_W'(tws_pkg::TOTAL_PHASES)) begin
            rsp_word.clock_pin = cur_phase[0];
            rsp_word.enable_pin = 1'b1;
            rsp_word.data_pin = reading ? 1'b0 : cur_out[0];
            rsp_word.data_drive = !reading;
            // sample on the low half before each rising edge
            if (reading && !cur_phase[0]) begin
               in_shift_in = {req_word.line_sample, cur_in[tws_pkg::BYTE_BITS-1:1]};
            end
            if (cur_phase[0]) begin
               out_shift_in = {1'b0, cur_out[tws_pkg::SHIFT_W-1:1]};
            end
            phase_in = cur_phase + tws_pkg::PHASE_W'(1);
            active_in = 1'b1;
         end else begin
            // closing tick: chip enable drops
            if (cur_read) begin
               rsp_word.read_byte = cur_in;
               rsp_word.read_done = 1'b1;
            end
            active_in = 1'b0;
            phase_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         out_shift_ff <= '0;
         in_shift_ff <= '0;
         is_read_ff <= 1'b0;
         active_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         out_shift_ff <= out_shift_in;
         in_shift_ff <= in_shift_in;
         is_read_ff <= is_read_in;
         active_ff <= active_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= tws_pkg::PHASE_W'(tws_pkg::TOTAL_PHASES))
      else $error("phase counter beyond closing tick");

   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (phase_ff == '0))
      else $error("idle with nonzero phase");

   a_start_enters: assert property (@(posedge clock) disable iff (reset)
      (step && !active_ff && start) |=> (active_ff && (phase_ff == tws_pkg::PHASE_W'(1))))
      else $error("start did not begin a transfer");

   a_close_ends: assert property (@(posedge clock) disable iff (reset)
      (step && active_ff && (phase_ff == tws_pkg::PHASE_W'(tws_pkg::TOTAL_PHASES)))
      |=> !active_ff)
      else $error("closing tick did not end the transfer");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for the three-wire serial register master
// depends on tws_pkg, tws_channels and the three_wire_serial_register_master top level
// drives half-period request words, predicts every response word and compares field by field

module tb_top;

   // scoreboard: tracks the bus transfer state and queues the pin words it predicts
   class serial_pin_board;
      tws_pkg::rsp_word_type expected_pins[$];
      int mismatches;
      int responses_seen;
      logic [5:0] half_phase;
      logic [tws_pkg::SHIFT_W-1:0] tx_shift;
      logic [tws_pkg::BYTE_BITS-1:0] rx_shift;
      logic reading;
      logic in_transfer;

      function new();
         mismatches = 0;
         responses_seen = 0;
         half_phase = '0;
         tx_shift = '0;
         rx_shift = '0;
         reading = 1'b0;
         in_transfer = 1'b0;
      endfunction

      function bit busy();
         return in_transfer;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      // one half period of an ongoing transfer, or the closing tick
      function void shift_half_period(logic line, inout tws_pkg::rsp_word_type pins);
         logic rx_half;
         if (half_phase < tws_pkg::TOTAL_PHASES) begin
            rx_half = reading && (half_phase >= 2 * tws_pkg::BYTE_BITS);
            pins.clock_pin = half_phase[0];
            pins.enable_pin = 1'b1;
            pins.data_pin = rx_half ? 1'b0 : tx_shift[0];
            pins.data_drive = !rx_half;
            // sample on the clock-low half before each rising edge, lsb first
            if (rx_half && !half_phase[0])
               rx_shift = {line, rx_shift[tws_pkg::BYTE_BITS-1:1]};
            if (half_phase[0])
               tx_shift = tx_shift >> 1;
            half_phase = half_phase + 6'd1;
         end else begin
            if (reading) begin
               pins.read_byte = rx_shift;
               pins.read_done = 1'b1;
            end
            in_transfer = 1'b0;
            half_phase = '0;
         end
      endfunction

      // an accepted request word: work out the response word it causes
      function void note_request(tws_pkg::req_word_type w);
         tws_pkg::rsp_word_type pins;
         logic start;
         logic rd;
         logic [tws_pkg::BYTE_BITS-1:0] cmd;
         pins = '0;
         start = (w.operation == tws_pkg::OP_WRITE) || (w.operation == tws_pkg::OP_READ);
         if (in_transfer) begin
            pins.busy_res = 1'b1;
            pins.start_rejected = start;
            shift_half_period(w.line_sample, pins);
         end else if (start) begin
            rd = (w.operation == tws_pkg::OP_READ);
            cmd = tws_pkg::CMD_BASE | (w.ram_select ? tws_pkg::CMD_RAM : 8'h00)
                  | {2'b00, w.reg_index, 1'b0} | (rd ? tws_pkg::CMD_READ : 8'h00);
            tx_shift = {w.write_data, cmd};
            rx_shift = '0;
            reading = rd;
            in_transfer = 1'b1;
            half_phase = '0;
            shift_half_period(w.line_sample, pins);
         end
         expected_pins.push_back(pins);
      endfunction

      task report(string what);
         $display("response %0d: %s", responses_seen, what);
         mismatches++;
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report($sformatf("%s is %0h, predicted %0h", name, got, want));
      endtask

      task check_pins(tws_pkg::rsp_word_type got);
         tws_pkg::rsp_word_type want;
         if (expected_pins.size() == 0) begin
            report("response word with nothing predicted");
         end else begin
            want = expected_pins.pop_front();
            compare_field("clock_pin", got.clock_pin, want.clock_pin);
            compare_field("enable_pin", got.enable_pin, want.enable_pin);
            compare_field("data_pin", got.data_pin, want.data_pin);
            compare_field("data_drive", got.data_drive, want.data_drive);
            compare_field("read_byte", got.read_byte, want.read_byte);
            compare_field("read_done", got.read_done, want.read_done);
            compare_field("busy_res", got.busy_res, want.busy_res);
            compare_field("start_rejected", got.start_rejected, want.start_rejected);
         end
         responses_seen++;
      endtask

      task check_leftovers();
         if (expected_pins.size() != 0)
            report($sformatf("%0d predicted words never arrived", expected_pins.size()));
      endtask
   endclass

   localparam int RANDOM_WORDS = 700;
   localparam int HOLD_OFF_CYCLES = 90;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;

   tws_req_if req_ch ();
   tws_rsp_if rsp_ch ();

   three_wire_serial_register_master DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   serial_pin_board board = new();

   int words_sent = 0;
   int stall_cycles = 0;
   bit steady = 1'b0;           // no idling on either side once set
   bit hold_off_request = 1'b0;

   always #1 clock = ~clock;

   // response side: every accepted word is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_pins(rsp_ch.payload);
   end

   // watchdog: too many cycles with no word moving on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, and one long hold-off so the block backs up
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!steady && $urandom_range(0, 11) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic tws_pkg::req_word_type random_word();
      tws_pkg::req_word_type w;
      w.operation = 2'($urandom_range(0, 3));
      w.ram_select = 1'($urandom());
      w.reg_index = 5'($urandom());
      w.write_data = 8'($urandom());
      w.line_sample = 1'($urandom());
      return w;
   endfunction

   // offer one request word, maybe after a sender gap, and wait for it to be taken
   task automatic send_word(tws_pkg::req_word_type w);
      if (!steady && $urandom_range(0, 19) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(w);
      words_sent++;
   endtask

   task automatic send_tick_word(logic [1:0] op);
      tws_pkg::req_word_type w;
      w = random_word();
      w.operation = op;
      send_word(w);
   endtask

   // sender stops until every predicted word has come back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // one full transfer: start word, 31 busy ticks with one intruding word, closing tick
   // line_byte is what the slave returns on a read, lsb first
   task automatic send_transfer(logic [1:0] op, logic ram, logic [4:0] idx,
                                logic [7:0] data, logic [7:0] line_byte,
                                logic [1:0] mid_op, logic [1:0] close_op);
      tws_pkg::req_word_type w;
      int mid_at;
      mid_at = $urandom_range(1, tws_pkg::TOTAL_PHASES - 1);
      // finish off any transfer left running by noise words
      while (board.busy()) send_tick_word(tws_pkg::OP_TICK);
      for (int p = 0; p <= tws_pkg::TOTAL_PHASES; p++) begin
         w = random_word();
         w.operation = tws_pkg::OP_TICK;
         if (p == 0) begin
            w.operation = op;
            w.ram_select = ram;
            w.reg_index = idx;
            w.write_data = data;
         end else if (p == mid_at) begin
            w.operation = mid_op;
         end else if (p == tws_pkg::TOTAL_PHASES) begin
            w.operation = close_op;
         end
         if (p >= 2 * tws_pkg::BYTE_BITS && p < tws_pkg::TOTAL_PHASES && (p % 2) == 0)
            w.line_sample = line_byte[(p - 2 * tws_pkg::BYTE_BITS) / 2];
         send_word(w);
      end
   endtask

   initial begin
      int random_start;
      bit held;
      bit paused;
      held = 1'b0;
      paused = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: idle ticks, the unused operation code while idle
      send_tick_word(tws_pkg::OP_TICK);
      send_tick_word(tws_pkg::OP_NONE);
      send_tick_word(tws_pkg::OP_TICK);
      // extremes of select, index and data; starts while busy and on the closing tick
      send_transfer(tws_pkg::OP_WRITE, 1'b1, 5'd31, 8'hff, 8'h00,
                    tws_pkg::OP_TICK, tws_pkg::OP_TICK);
      send_transfer(tws_pkg::OP_WRITE, 1'b0, 5'd0, 8'h00, 8'hff,
                    tws_pkg::OP_READ, tws_pkg::OP_WRITE);
      send_transfer(tws_pkg::OP_READ, 1'b1, 5'd31, 8'h00, 8'hff,
                    tws_pkg::OP_WRITE, tws_pkg::OP_TICK);
      send_transfer(tws_pkg::OP_READ, 1'b0, 5'd0, 8'hff, 8'h00,
                    tws_pkg::OP_TICK, tws_pkg::OP_READ);
      // back-to-back transfers: start on the word right after a closing tick
      send_transfer(tws_pkg::OP_READ, 1'b0, 5'b10101, 8'h3c, 8'ha5,
                    tws_pkg::OP_NONE, tws_pkg::OP_NONE);
      send_transfer(tws_pkg::OP_WRITE, 1'b1, 5'b01010, 8'h5a, 8'h5a,
                    tws_pkg::OP_WRITE, tws_pkg::OP_TICK);
      send_transfer(tws_pkg::OP_READ, 1'b1, 5'b01010, 8'hc3, 8'h5a,
                    tws_pkg::OP_READ, tws_pkg::OP_WRITE);
      drain_responses();

      // random: mostly well-formed transfers with random content, some noise words
      random_start = words_sent;
      while (words_sent - random_start < RANDOM_WORDS) begin
         steady = (words_sent - random_start > RANDOM_WORDS - 100);
         if (!held && words_sent - random_start > 250) begin
            held = 1'b1;
            hold_off_request = 1'b1;
         end
         if (!paused && words_sent - random_start > 450) begin
            paused = 1'b1;
            drain_responses();
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 20)) send_word(random_word());
         end else begin
            send_transfer(2'($urandom_range(1, 2)), 1'($urandom()), 5'($urandom()),
                          8'($urandom()), 8'($urandom()),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         end
      end

      // let the last words come back, then give stray responses time to appear
      drain_responses();
      repeat (8) @(posedge clock);
      board.check_leftovers();
      if (board.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
design/tws_pkg.sv
design/tws_channels.sv
design/tws_core.sv
design/three_wire_serial_register_master.sv
bench/tb_top.sv
